// File: hdl/dlrb_pkg.sv
// Shared types, codes and defaults for the device loss retry backoff block.
package dlrb_pkg;

    // Default parameter values.
    localparam int TIME_WIDTH_DEF    = 32;
    localparam int ATTEMPT_WIDTH_DEF = 8;

    // Register widths, fixed by the register map.
    localparam int FIRST_W  = 16;
    localparam int CAP_W    = 24;
    localparam int FACTOR_W = 12;
    localparam int LIMIT_W  = 8;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 4;

    // Working backoff value: cap scaled by 256 fits in 32 bits, and one
    // step on a value below that grows to at most 36 bits.
    localparam int VAL_W  = CAP_W + 12;
    localparam int MULA_W = CAP_W + 8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 4'd3;

    // Register reset values.
    localparam logic [FIRST_W-1:0]  FIRST_RST  = 16'd500;
    localparam logic [CAP_W-1:0]    CAP_RST    = 24'd30000;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 12'd512;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 8'd0;

    // Operation codes.
    localparam logic [2:0] OP_RUNNING    = 3'd0;
    localparam logic [2:0] OP_LOST       = 3'd1;
    localparam logic [2:0] OP_RETRY_FAIL = 3'd2;
    localparam logic [2:0] OP_RETRY_OK   = 3'd3;
    localparam logic [2:0] OP_ACK        = 3'd4;

    // Health codes.
    localparam logic [1:0] H_RUNNING  = 2'd0;
    localparam logic [1:0] H_LOST     = 2'd1;
    localparam logic [1:0] H_RESTORED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the input word
        logic apply;     // apply an event that needs no backoff calculation
        logic start;     // failed retry: count it and seed the backoff value
        logic step;      // one backoff multiplication
        logic finish;    // schedule the retry from the backoff value
        logic load_out;  // load the result register
    } dlrb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic retry_lost;  // latched event is a failed retry while lost
        logic calc_done;   // backoff value reached the cap or the count
    } dlrb_sts_t;

endpackage

// File: hdl/device_loss_retry_backoff.sv
// Top level of the device loss retry backoff block.
//
//  Channel   Direction  Carries
//  s_axis    in         tuser[2:0] operation; tdata now_ms
//  m_axis    out        tdata health, retry_now, wait_ms, given_up, ack_ok,
//                       attempt_count
//  cfg       in         cfg_we, cfg_index, cfg_data (one write per cycle)
//
// An event is accepted only in the idle state and passes through accept,
// evaluate and result load before the next event can enter the block.
// A failed retry while lost adds backoff multiplications, at most
// 2^ATTEMPT_WIDTH-1 of them on the single multiplier, and a finish step.
// The result register lets the next event be taken while a result waits;
// a stalled output holds the block before its result load.
// Reset is asynchronous and restores the running state and register defaults.
module device_loss_retry_backoff
    import dlrb_pkg::*;
#(
    parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
    parameter int ATTEMPT_WIDTH = ATTEMPT_WIDTH_DEF,
    localparam int IN_DW  = ((TIME_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((TIME_WIDTH + ATTEMPT_WIDTH + 5 + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DW-1:0]     s_axis_tdata,   // now_ms
    input  logic [2:0]           s_axis_tuser,   // operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // health, retry_now, wait_ms, given_up, ack_ok, attempt_count
    output logic [OUT_DW-1:0]    m_axis_tdata
);

    localparam int PAD_W = OUT_DW - (TIME_WIDTH + ATTEMPT_WIDTH + 5);

    dlrb_cmd_t                cmd;
    dlrb_sts_t                sts;
    logic [1:0]               health;
    logic                     retry_now;
    logic [TIME_WIDTH-1:0]    wait_ms;
    logic                     given_up;
    logic                     ack_ok;
    logic [ATTEMPT_WIDTH-1:0] attempt_count;

    // Sequencing.
    dlrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // State, arithmetic and result register.
    dlrb_dp #(
        .TIME_WIDTH    (TIME_WIDTH),
        .ATTEMPT_WIDTH (ATTEMPT_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_operation      (s_axis_tuser),
        .in_now_ms         (s_axis_tdata[TIME_WIDTH-1:0]),
        .cmd               (cmd),
        .sts               (sts),
        .out_health        (health),
        .out_retry_now     (retry_now),
        .out_wait_ms       (wait_ms),
        .out_given_up      (given_up),
        .out_ack_ok        (ack_ok),
        .out_attempt_count (attempt_count)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_axis_tdata = {{PAD_W{1'b0}}, attempt_count, ack_ok, given_up,
                           wait_ms, retry_now, health};

endmodule

// File: hdl/dlrb_ctrl.sv
// Controller state machine for the device loss retry backoff block.
module dlrb_ctrl
    import dlrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dlrb_sts_t sts,
    output dlrb_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_CALC,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result register is free when empty or being drained.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.retry_lost)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CALC;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_CALC:
            begin
                if (sts.calc_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/dlrb_dp.sv
// Datapath for the device loss retry backoff block: registers, health
// state, backoff multiplier and result register.
module dlrb_dp
    import dlrb_pkg::*;
#(
    parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
    parameter int ATTEMPT_WIDTH = ATTEMPT_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic [2:0]               in_operation,
    input  logic [TIME_WIDTH-1:0]    in_now_ms,
    input  dlrb_cmd_t                cmd,
    output dlrb_sts_t                sts,
    output logic [1:0]               out_health,
    output logic                     out_retry_now,
    output logic [TIME_WIDTH-1:0]    out_wait_ms,
    output logic                     out_given_up,
    output logic                     out_ack_ok,
    output logic [ATTEMPT_WIDTH-1:0] out_attempt_count
);

    localparam int SUM_W = ((TIME_WIDTH > CAP_W) ? TIME_WIDTH : CAP_W) + 1;
    localparam int CMP_W = (ATTEMPT_WIDTH > LIMIT_W) ? ATTEMPT_WIDTH : LIMIT_W;
    localparam logic [SUM_W-1:0] TIME_MAX =
        {{(SUM_W-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
    localparam logic [ATTEMPT_WIDTH-1:0] ATT_MAX = {ATTEMPT_WIDTH{1'b1}};

    // Saturating time sum.
    function automatic logic [TIME_WIDTH-1:0] sat_add(
        input logic [TIME_WIDTH-1:0] a,
        input logic [CAP_W-1:0]      b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > TIME_MAX)
            sat_add = {TIME_WIDTH{1'b1}};
        else
            sat_add = s[TIME_WIDTH-1:0];
    endfunction

    logic [FIRST_W-1:0]       first_reg;
    logic [CAP_W-1:0]         cap_reg;
    logic [FACTOR_W-1:0]      factor_reg;
    logic [LIMIT_W-1:0]       limit_reg;
    logic [1:0]               health_reg;
    logic [ATTEMPT_WIDTH-1:0] attempts_reg;
    logic [ATTEMPT_WIDTH-1:0] attempts_next;
    logic [TIME_WIDTH-1:0]    due_reg;
    logic                     ack_reg;
    logic [2:0]               op_reg;
    logic [TIME_WIDTH-1:0]    now_reg;
    logic [VAL_W-1:0]         val_reg;
    logic [ATTEMPT_WIDTH-1:0] cnt_reg;

    logic [MULA_W-1:0]          capq;
    logic [MULA_W+FACTOR_W-1:0] product;
    logic [VAL_W-8-1:0]         val_int;
    logic [CAP_W-1:0]           interval;
    logic                       given_up;

    // Backoff arithmetic. The multiplier only runs while the value is
    // below the scaled cap, so its low 32 bits hold all of it.
    assign capq     = {cap_reg, 8'd0};
    assign product  = val_reg[MULA_W-1:0] * factor_reg;
    assign val_int  = val_reg[VAL_W-1:8];
    assign interval = (val_int < (VAL_W-8)'(cap_reg)) ? val_int[CAP_W-1:0] : cap_reg;
    assign attempts_next = (attempts_reg < ATT_MAX) ? attempts_reg + 1'b1 : attempts_reg;

    assign sts.retry_lost = (op_reg == OP_RETRY_FAIL) && (health_reg == H_LOST);
    assign sts.calc_done  = (cnt_reg == attempts_reg) || (val_reg >= VAL_W'(capq));

    assign given_up = (limit_reg != '0) &&
                      (CMP_W'(attempts_reg) >= CMP_W'(limit_reg));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= FIRST_RST;
            cap_reg    <= CAP_RST;
            factor_reg <= FACTOR_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIRST:  first_reg  <= cfg_data[FIRST_W-1:0];
                REG_CAP:    cap_reg    <= cfg_data[CAP_W-1:0];
                REG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Health state, attempt count and retry schedule.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            health_reg   <= H_RUNNING;
            attempts_reg <= '0;
            due_reg      <= '0;
            ack_reg      <= 1'b0;
        end
        else if (cmd.start)
        begin
            attempts_reg <= attempts_next;
            ack_reg      <= 1'b0;
        end
        else if (cmd.finish)
        begin
            due_reg <= sat_add(now_reg, interval);
        end
        else if (cmd.apply)
        begin
            ack_reg <= 1'b0;
            unique case (op_reg)
                OP_RUNNING:
                begin
                    health_reg   <= H_RUNNING;
                    attempts_reg <= '0;
                    due_reg      <= '0;
                end
                OP_LOST:
                begin
                    if (health_reg != H_LOST)
                    begin
                        health_reg   <= H_LOST;
                        attempts_reg <= '0;
                        due_reg      <= sat_add(now_reg, CAP_W'(first_reg));
                    end
                end
                OP_RETRY_OK:
                begin
                    if (health_reg == H_LOST)
                    begin
                        health_reg <= H_RESTORED;
                        due_reg    <= '0;
                    end
                end
                OP_ACK:
                begin
                    if (health_reg == H_RESTORED)
                    begin
                        health_reg   <= H_RUNNING;
                        attempts_reg <= '0;
                        due_reg      <= '0;
                        ack_reg      <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Input capture and the backoff iteration.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= in_operation;
            now_reg <= in_now_ms;
        end
        if (cmd.start)
        begin
            val_reg <= VAL_W'({first_reg, 8'd0});
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            val_reg <= product[MULA_W+FACTOR_W-1:8];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_health        <= health_reg;
            out_retry_now     <= (health_reg == H_LOST) && !given_up &&
                                 (now_reg >= due_reg);
            out_wait_ms       <= ((health_reg == H_LOST) && (due_reg > now_reg)) ?
                                 due_reg - now_reg : '0;
            out_given_up      <= given_up;
            out_ack_ok        <= ack_reg;
            out_attempt_count <= attempts_reg;
        end
    end

endmodule

// File: bench/device_loss_retry_backoff_tb.sv
// Self-checking testbench for the device loss retry backoff block.
module device_loss_retry_backoff_tb;
    import dlrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes that the package does not name.
    localparam logic [2:0] OP_POLL     = 3'd5;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int OUT_W        = 48;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLDOFF_LEN  = 400;
    localparam int DRAIN_CYCLES = 300;

    // Result word, health in the lowest bits.
    typedef struct packed {
        logic [7:0]  attempt_count;
        logic        ack_ok;
        logic        given_up;
        logic [31:0] wait_ms;
        logic        retry_now;
        logic [1:0]  health;
    } status_word_t;

    // Tracks the device health and register settings, and holds the
    // status words still owed by the block.
    class health_scoreboard;
        logic [FIRST_W-1:0]  first_delay;
        logic [CAP_W-1:0]    cap_delay;
        logic [FACTOR_W-1:0] growth;
        logic [LIMIT_W-1:0]  limit;
        logic [1:0]          health;
        logic [7:0]          attempts;
        logic [31:0]         due;
        status_word_t        expected_q[$];
        int mismatches;
        int events_noted;
        int results_checked;
        int retry_hits;
        int giveup_hits;
        int ack_hits;
        int max_attempts;

        function new();
            first_delay = FIRST_RST;
            cap_delay   = CAP_RST;
            growth      = FACTOR_RST;
            limit       = LIMIT_RST;
            health      = H_RUNNING;
            attempts    = '0;
            due         = '0;
            mismatches  = 0;
            events_noted = 0;
            results_checked = 0;
            retry_hits  = 0;
            giveup_hits = 0;
            ack_hits    = 0;
            max_attempts = 0;
        endfunction

        // Register write; unmapped indexes change nothing.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_FIRST:  first_delay = val[FIRST_W-1:0];
                REG_CAP:    cap_delay   = val[CAP_W-1:0];
                REG_FACTOR: growth      = val[FACTOR_W-1:0];
                REG_LIMIT:  limit       = val[LIMIT_W-1:0];
                default:    ;
            endcase
        endfunction

        // Time sum that sticks at the largest time value.
        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // Backoff interval for the current attempt count, Q.8 working value.
        function logic [31:0] backoff_interval();
            logic [63:0] v;
            logic [63:0] capq;
            capq = {32'd0, cap_delay, 8'd0};
            v    = {40'd0, first_delay, 8'd0};
            for (int i = 0; i < attempts; i++)
            begin
                if (v >= capq)
                    break;
                v = (v * growth) >> 8;
                if (v >= capq)
                    break;
            end
            v = v >> 8;
            return (v < cap_delay) ? v[31:0] : {8'd0, cap_delay};
        endfunction

        // Apply one accepted event and queue the status word it yields.
        function void note_event(logic [2:0] op, logic [31:0] now);
            status_word_t w;
            logic ack;
            logic gave;
            ack = 1'b0;
            case (op)
                OP_RUNNING:
                begin
                    health   = H_RUNNING;
                    attempts = '0;
                    due      = '0;
                end
                OP_LOST:
                begin
                    if (health != H_LOST)
                    begin
                        health   = H_LOST;
                        attempts = '0;
                        due      = sat_add(now, {16'd0, first_delay});
                    end
                end
                OP_RETRY_FAIL:
                begin
                    if (health == H_LOST)
                    begin
                        if (attempts != 8'hFF)
                            attempts = attempts + 8'd1;
                        due = sat_add(now, backoff_interval());
                    end
                end
                OP_RETRY_OK:
                begin
                    if (health == H_LOST)
                    begin
                        health = H_RESTORED;
                        due    = '0;
                    end
                end
                OP_ACK:
                begin
                    if (health == H_RESTORED)
                    begin
                        health   = H_RUNNING;
                        attempts = '0;
                        due      = '0;
                        ack      = 1'b1;
                    end
                end
                default: ;
            endcase
            gave = (limit != 0) && (attempts >= limit);
            w.health        = health;
            w.retry_now     = (health == H_LOST) && !gave && (now >= due);
            w.wait_ms       = (health == H_LOST && due > now) ? due - now : 32'd0;
            w.given_up      = gave;
            w.ack_ok        = ack;
            w.attempt_count = attempts;
            expected_q.push_back(w);
            events_noted++;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 200)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] exp);
            if (got !== exp)
                report($sformatf("%s got %0h, expected %0h (result %0d)",
                                 name, got, exp, results_checked));
        endtask

        // Compare one accepted status word against the oldest expectation.
        task check_status(logic [OUT_W-1:0] data);
            status_word_t got;
            status_word_t exp;
            got = data[$bits(status_word_t)-1:0];
            if (expected_q.size() == 0)
            begin
                report($sformatf("status word %h with no event pending", data));
            end
            else
            begin
                exp = expected_q.pop_front();
                check_field("health", got.health, exp.health);
                check_field("retry_now", got.retry_now, exp.retry_now);
                check_field("wait_ms", got.wait_ms, exp.wait_ms);
                check_field("given_up", got.given_up, exp.given_up);
                check_field("ack_ok", got.ack_ok, exp.ack_ok);
                check_field("attempt_count", got.attempt_count, exp.attempt_count);
                results_checked++;
                retry_hits  += exp.retry_now;
                giveup_hits += exp.given_up;
                ack_hits    += exp.ack_ok;
                if (exp.attempt_count > max_attempts)
                    max_attempts = exp.attempt_count;
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // now_ms
    logic [2:0]           s_axis_tuser;   // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // health, retry_now, wait_ms, given_up, ack_ok, attempt_count
    logic [OUT_W-1:0]     m_axis_tdata;

    health_scoreboard sb = new();

    int          burst_left = 0;
    int          item_count = 0;
    int          settings_used = 0;
    logic [31:0] clock_ms = '0;
    bit          holdoff_req = 1'b0;

    device_loss_retry_backoff u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Offer one event word; bursts of random length with random gaps.
    task send_event(input logic [2:0] op, input logic [31:0] now);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= now;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_event(op, now);
        burst_left--;
        item_count++;
    endtask

    // Stop offering and wait until every status word has come back.
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task apply_settings(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] cap,
                        input logic [CFG_W-1:0] factor, input logic [CFG_W-1:0] lim);
        wait_idle();
        write_reg(REG_FIRST, first);
        write_reg(REG_CAP, cap);
        write_reg(REG_FACTOR, factor);
        write_reg(REG_LIMIT, lim);
        settings_used++;
    endtask

    // Event time: mostly forward steps, some hits at or next to the retry time,
    // and a few jumps anywhere, including backward and near the top.
    function logic [31:0] pick_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20 && sb.health == H_LOST)
            clock_ms = sb.due + $urandom_range(0, 2) - 1;
        else if (r < 60)
            clock_ms = clock_ms + $urandom_range(0, 1000);
        else if (r < 85)
            clock_ms = clock_ms + $urandom_range(0, 100000);
        else if (r < 95)
            clock_ms = clock_ms + $urandom_range(0, 20000000);
        else if (r < 98)
            clock_ms = $urandom();
        else
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
        return clock_ms;
    endfunction

    // A loss, a run of failed retries with polls and noise, then usually recovery.
    task run_episode(input int max_fails);
        int n;
        int r;
        send_event(OP_LOST, pick_time());
        n = $urandom_range(0, max_fails);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                send_event(OP_RETRY_FAIL, pick_time());
            else if (r < 80)
                send_event(OP_POLL, pick_time());
            else if (r < 88)
                send_event(OP_LOST, pick_time());
            else
                send_event(3'($urandom_range(0, 7)), pick_time());
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            send_event(OP_RETRY_OK, pick_time());
            if ($urandom_range(0, 9) < 7)
                send_event(OP_ACK, pick_time());
            else
                send_event(OP_POLL, pick_time());
        end
        else if (r < 80)
        begin
            send_event(OP_RUNNING, pick_time());
        end
    endtask

    task run_random(input int upto, input int max_fails);
        while (item_count < upto)
        begin
            if ($urandom_range(0, 99) < 80)
                run_episode(max_fails);
            else
                send_event(3'($urandom_range(0, 7)), pick_time());
        end
    endtask

    // Receiver: random ready runs of its own, plus a long hold-off on request.
    initial
    begin
        int run_left;
        int hold_left;
        bit level;
        run_left  = 0;
        hold_left = 0;
        level     = 1'b1;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_status(m_axis_tdata);
            if (holdoff_req)
            begin
                hold_left   = HOLDOFF_LEN;
                holdoff_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        level    = 1'b1;
                        run_left = $urandom_range(20, 60);
                    end
                    else
                    begin
                        level    = ($urandom_range(0, 99) < 70);
                        run_left = $urandom_range(1, 8);
                    end
                end
                run_left--;
                m_axis_tready <= level;
            end
        end
    end

    // Watchdog: too many cycles with no word moving on either side.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        settings_used = 1;

        // Directed events under the reset settings.
        send_event(OP_POLL, 32'd0);
        send_event(OP_ACK, 32'd10);
        send_event(OP_RETRY_FAIL, 32'd20);
        send_event(OP_RETRY_OK, 32'd30);
        send_event(OP_LOST, 32'd1000);
        send_event(OP_LOST, 32'd1200);
        send_event(OP_POLL, 32'd1499);
        send_event(OP_POLL, 32'd1500);
        send_event(OP_RETRY_FAIL, 32'd1600);
        send_event(OP_RETRY_FAIL, 32'd2600);
        send_event(OP_RETRY_FAIL, 32'd4600);
        send_event(OP_SPARE_LO, 32'd8000);
        send_event(OP_SPARE_HI, 32'd8700);
        send_event(OP_RETRY_OK, 32'd9000);
        send_event(OP_RETRY_FAIL, 32'd9100);
        send_event(OP_ACK, 32'd9200);
        send_event(OP_ACK, 32'd9300);
        // Loss near the top of the time range saturates the retry time.
        send_event(OP_LOST, 32'hFFFF_FF00);
        send_event(OP_RETRY_FAIL, 32'hFFFF_FFFF);
        send_event(OP_POLL, 32'd0);
        send_event(OP_RUNNING, 32'd5);
        send_event(OP_POLL, 32'd6);
        clock_ms = 32'd10000;

        // Reset settings, with a long receiver hold-off partway through.
        run_random(120, 12);
        holdoff_req = 1'b1;
        run_random(230, 12);

        // Largest register values.
        apply_settings(24'd65535, 24'd16777215, 24'd4095, 24'd255);
        run_random(430, 12);

        // Delay and cap of one, unit factor, limit of one; one failed retry gives up.
        apply_settings(24'd1, 24'd1, 24'd256, 24'd1);
        run_random(620, 8);

        // Unit factor never reaches the cap: drive the count to saturation.
        apply_settings(24'd7, 24'd16777215, 24'd256, 24'd200);
        send_event(OP_LOST, pick_time());
        repeat (270)
        begin
            if ($urandom_range(0, 9) == 0)
                send_event(OP_POLL, pick_time());
            send_event(OP_RETRY_FAIL, pick_time());
        end
        send_event(OP_RETRY_OK, pick_time());
        send_event(OP_ACK, pick_time());

        // Zero delay, cap and factor.
        apply_settings(24'd0, 24'd0, 24'd0, 24'd3);
        run_random(1060, 10);

        // Factor below one shrinks the interval; sender drains midway.
        apply_settings(24'd40000, 24'd5000000, 24'd100, 24'd0);
        run_random(1130, 12);
        wait_idle();
        run_random(1210, 12);

        // Random full-width settings, with a write to an unmapped index.
        repeat (4)
        begin
            apply_settings(CFG_W'($urandom()), CFG_W'($urandom()),
                           CFG_W'($urandom()), CFG_W'($urandom()));
            write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_W'($urandom()));
            run_random(item_count + 170, 12);
        end

        // Drain and let the block settle.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d status words never arrived", sb.expected_q.size()));

        $display("Ran %0d events under %0d register settings; %0d status words checked.",
                 sb.events_noted, settings_used, sb.results_checked);
        $display("Saw %0d retry-due words, %0d give-ups, %0d acknowledges, attempts up to %0d.",
                 sb.retry_hits, sb.giveup_hits, sb.ack_hits, sb.max_attempts);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
hdl/dlrb_pkg.sv
hdl/dlrb_ctrl.sv
hdl/dlrb_dp.sv
hdl/device_loss_retry_backoff.sv
bench/device_loss_retry_backoff_tb.sv
